FILE: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps

package ffha_pkg;

  // Heap geometry.
  localparam int MEM_BYTES    = 4096;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_BLOCKS   = MEM_BYTES / HEADER_BYTES;

  // Field and datapath widths.
  localparam int ADDR_W = 12;   // byte offset into the heap
  localparam int SIZE_W = 13;   // block size, header included
  localparam int HDR_W  = 14;   // busy bit on top of the size
  localparam int OFF_W  = 14;   // walk offset, may run past the heap end
  localparam int CNT_W  = 11;   // busy block count
  localparam int ALU_W  = 15;   // shared add/subtract unit

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CAPACITY  = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_NULL_FREE = 2'd3
  } status_t;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_NEED  = 15'h0004,
    S_CAP0  = 15'h0008,
    S_CAP1  = 15'h0010,
    S_WALK  = 15'h0020,
    S_EVAL  = 15'h0040,
    S_ADV   = 15'h0080,
    S_G1    = 15'h0100,
    S_G2    = 15'h0200,
    S_G3    = 15'h0400,
    S_F0    = 15'h0800,
    S_FEV   = 15'h1000,
    S_FPAY  = 15'h2000,
    S_DONE  = 15'h4000
  } state_t;

endpackage

FILE: hw/rtl/ffha_ram.sv
`timescale 1ns / 1ps

module ffha_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data holds its value until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// A free reads at most one header; an allocate checks capacity and then walks the header chain, one
// RAM read per header stepped over; refusals finish sooner. A finished result waits while the output
// register is still occupied. Throughput: one request at a time; the next request is taken once the
// result is registered. Reset: synchronous, active low; afterwards a clearing pass zeroes the header
// RAM (one entry per cycle) and no request is accepted until it is done.

module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [12:0] request_bytes, [24:13] free_address, rest zero
  input  logic [0:0]  in_tuser,   // [0] op (0 allocate, 1 free)
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [0] ok, [12:1] result_address, [14:13] status,
                                  // [25:15] blocks_in_use, [38:26] bytes_allocated, [39] zero
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int HW = ffha_pkg::HDR_W;
  localparam int OW = ffha_pkg::OFF_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam int XW = ffha_pkg::ALU_W;

  // Sequencer state and request registers.
  ffha_pkg::state_t  state_r, state_nxt;
  ffha_pkg::op_t     op_r, op_nxt;
  logic [SW-1:0]     req_r, req_nxt;
  logic [AW-1:0]     faddr_r, faddr_nxt;

  // Working registers of the walk.
  logic [OW-1:0]     need_r, need_nxt;     // request plus header
  logic [XW-1:0]     tmp_r, tmp_nxt;       // intermediate sums
  logic [OW-1:0]     off_r, off_nxt;       // current header offset
  logic [AW-1:0]     hdr_addr_r, hdr_addr_nxt;
  logic [SW-1:0]     gsz_r, gsz_nxt;       // size of the granted block
  logic [SW-1:0]     pay_r, pay_nxt;       // payload released by a free
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;

  // Allocator bookkeeping.
  logic [CW-1:0]     busy_cnt_r, busy_cnt_nxt;
  logic [SW-1:0]     payload_r, payload_nxt;

  // Result being built and the output register.
  logic              res_ok_r, res_ok_nxt;
  logic [AW-1:0]     res_addr_r, res_addr_nxt;
  ffha_pkg::status_t res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       out_data_r, out_data_nxt;

  // The one shared add/subtract unit. The size, offset and payload sums of the sequencer go through it;
  // on a subtraction the top bit of the result is the borrow. The counters step on their own.
  logic [XW-1:0]     alu_a, alu_b, alu_y;
  logic              alu_sub;

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(XW-1){1'b0}}, alu_sub};

  // Header RAM port. Each header holds the busy bit over the block size.
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [HW-1:0]     ram_wdata, ram_rdata;
  logic              rd_busy;
  logic [SW-1:0]     rd_size;

  assign rd_busy = ram_rdata[HW-1];
  assign rd_size = ram_rdata[SW-1:0];

  ffha_ram #(
    .WIDTH (HW),
    .DEPTH (ffha_pkg::MEM_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A new request is taken only while the sequencer is idle. The finished result sits in the
  // output register, so the next request can start while that result waits to be taken.
  assign in_tready  = (state_r == ffha_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    faddr_nxt      = faddr_r;
    need_nxt       = need_r;
    tmp_nxt        = tmp_r;
    off_nxt        = off_r;
    hdr_addr_nxt   = hdr_addr_r;
    gsz_nxt        = gsz_r;
    pay_nxt        = pay_r;
    clr_cnt_nxt    = clr_cnt_r;
    busy_cnt_nxt   = busy_cnt_r;
    payload_nxt    = payload_r;
    res_ok_nxt     = res_ok_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hdr_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = off_r[AW-1:0];

    unique case (state_r)
      ffha_pkg::S_CLEAR: begin
        // Zero one header per cycle: free, size zero.
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {AW{1'b1}}) begin
          state_nxt = ffha_pkg::S_IDLE;
        end
      end

      ffha_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = ffha_pkg::op_t'(in_tuser[0]);
          req_nxt        = in_tdata[SW-1:0];
          faddr_nxt      = in_tdata[SW+AW-1:SW];
          res_ok_nxt     = 1'b0;
          res_addr_nxt   = '0;
          res_status_nxt = ffha_pkg::ST_OK;
          state_nxt      = (in_tuser[0] == ffha_pkg::OP_FREE) ? ffha_pkg::S_F0
                                                               : ffha_pkg::S_NEED;
        end
      end

      ffha_pkg::S_NEED: begin
        alu_a     = XW'(req_r);
        alu_b     = XW'(ffha_pkg::HEADER_BYTES);
        need_nxt  = alu_y[OW-1:0];
        state_nxt = ffha_pkg::S_CAP0;
      end

      ffha_pkg::S_CAP0: begin
        // Bytes in use: payload plus one header per busy block.
        alu_a     = XW'(payload_r);
        alu_b     = XW'({busy_cnt_r, 2'b00});
        tmp_nxt   = alu_y;
        state_nxt = ffha_pkg::S_CAP1;
      end

      ffha_pkg::S_CAP1: begin
        // The request fails when need exceeds what is left of the heap.
        alu_a = tmp_r;
        alu_b = XW'(need_r);
        if (alu_y > XW'(ffha_pkg::MEM_BYTES)) begin
          res_status_nxt = ffha_pkg::ST_CAPACITY;
          state_nxt      = ffha_pkg::S_DONE;
        end else begin
          off_nxt   = '0;
          state_nxt = ffha_pkg::S_WALK;
        end
      end

      ffha_pkg::S_WALK: begin
        // Keep walking only while a block of this size would still end inside the heap.
        alu_a = XW'(off_r);
        alu_b = XW'(need_r);
        if (alu_y < XW'(ffha_pkg::MEM_BYTES)) begin
          ram_re       = 1'b1;
          ram_raddr    = off_r[AW-1:0];
          hdr_addr_nxt = off_r[AW-1:0];
          state_nxt    = ffha_pkg::S_EVAL;
        end else begin
          res_status_nxt = ffha_pkg::ST_NO_FIT;
          state_nxt      = ffha_pkg::S_DONE;
        end
      end

      ffha_pkg::S_EVAL: begin
        // Borrow of need minus size tells that the free block is larger than needed.
        alu_a   = XW'(need_r);
        alu_b   = XW'(rd_size);
        alu_sub = 1'b1;
        if (!rd_busy && (rd_size == '0)) begin
          // End of the chain: open a new block at the tail.
          ram_we    = 1'b1;
          ram_wdata = {1'b1, need_r[SW-1:0]};
          gsz_nxt   = need_r[SW-1:0];
          state_nxt = ffha_pkg::S_G1;
        end else if (!rd_busy && alu_y[XW-1]) begin
          // Reuse the whole free block without splitting it.
          ram_we    = 1'b1;
          ram_wdata = {1'b1, rd_size};
          gsz_nxt   = rd_size;
          state_nxt = ffha_pkg::S_G1;
        end else if (rd_busy && (rd_size == '0)) begin
          // A busy header of size zero cannot be stepped over.
          res_status_nxt = ffha_pkg::ST_NO_FIT;
          state_nxt      = ffha_pkg::S_DONE;
        end else begin
          state_nxt = ffha_pkg::S_ADV;
        end
      end

      ffha_pkg::S_ADV: begin
        // Read data still holds the header, so step to the next one.
        alu_a     = XW'(off_r);
        alu_b     = XW'(rd_size);
        off_nxt   = alu_y[OW-1:0];
        state_nxt = ffha_pkg::S_WALK;
      end

      ffha_pkg::S_G1: begin
        alu_a        = XW'(payload_r);
        alu_b        = XW'(gsz_r);
        tmp_nxt      = alu_y;
        busy_cnt_nxt = busy_cnt_r + 1'b1;
        state_nxt    = ffha_pkg::S_G2;
      end

      ffha_pkg::S_G2: begin
        // The header itself does not count as payload.
        alu_a       = tmp_r;
        alu_b       = XW'(ffha_pkg::HEADER_BYTES);
        alu_sub     = 1'b1;
        payload_nxt = alu_y[SW-1:0];
        state_nxt   = ffha_pkg::S_G3;
      end

      ffha_pkg::S_G3: begin
        alu_a          = XW'(hdr_addr_r);
        alu_b          = XW'(ffha_pkg::HEADER_BYTES);
        res_addr_nxt   = alu_y[AW-1:0];
        res_ok_nxt     = 1'b1;
        res_status_nxt = ffha_pkg::ST_OK;
        state_nxt      = ffha_pkg::S_DONE;
      end

      ffha_pkg::S_F0: begin
        alu_a   = XW'(faddr_r);
        alu_b   = XW'(ffha_pkg::HEADER_BYTES);
        alu_sub = 1'b1;
        if (faddr_r == '0) begin
          res_status_nxt = ffha_pkg::ST_NULL_FREE;
          state_nxt      = ffha_pkg::S_DONE;
        end else if (alu_y[XW-1]) begin
          // An address inside the first header frees nothing but still succeeds.
          res_ok_nxt = 1'b1;
          state_nxt  = ffha_pkg::S_DONE;
        end else begin
          ram_re       = 1'b1;
          ram_raddr    = alu_y[AW-1:0];
          hdr_addr_nxt = alu_y[AW-1:0];
          state_nxt    = ffha_pkg::S_FEV;
        end
      end

      ffha_pkg::S_FEV: begin
        alu_a   = XW'(rd_size);
        alu_b   = XW'(ffha_pkg::HEADER_BYTES);
        alu_sub = 1'b1;
        if (!rd_busy) begin
          res_ok_nxt = 1'b1;
          state_nxt  = ffha_pkg::S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, rd_size};
          if (busy_cnt_r != '0) begin
            busy_cnt_nxt = busy_cnt_r - 1'b1;
          end
          pay_nxt   = alu_y[XW-1] ? '0 : alu_y[SW-1:0];
          state_nxt = ffha_pkg::S_FPAY;
        end
      end

      ffha_pkg::S_FPAY: begin
        // Payload total saturates at zero.
        alu_a       = XW'(payload_r);
        alu_b       = XW'(pay_r);
        alu_sub     = 1'b1;
        payload_nxt = alu_y[XW-1] ? '0 : alu_y[SW-1:0];
        res_ok_nxt  = 1'b1;
        state_nxt   = ffha_pkg::S_DONE;
      end

      ffha_pkg::S_DONE: begin
        // Load the output register once the previous result has left.
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, payload_r, busy_cnt_r, res_status_r, res_addr_r, res_ok_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ffha_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      busy_cnt_r  <= '0;
      payload_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      busy_cnt_r  <= busy_cnt_nxt;
      payload_r   <= payload_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    faddr_r      <= faddr_nxt;
    need_r       <= need_nxt;
    tmp_r        <= tmp_nxt;
    off_r        <= off_nxt;
    hdr_addr_r   <= hdr_addr_nxt;
    gsz_r        <= gsz_nxt;
    pay_r        <= pay_nxt;
    res_ok_r     <= res_ok_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // A request is taken only from idle, so the cycle after an accept is never ready.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in progress");

  // Blocks are at least one header long, so the busy count stays within the heap.
  a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_cnt_r <= CW'(ffha_pkg::MAX_BLOCKS))
    else $error("busy block count out of range");

  // The clearing pass neither takes requests nor produces results.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffha_pkg::S_CLEAR) |-> (!in_tready && !out_tvalid))
    else $error("activity during the clearing pass");

  // The header RAM is never asked to read and write in the same cycle.
  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("header RAM read and write collide");

  // A header is only written in the cycle after it was read, except while clearing.
  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r != ffha_pkg::S_CLEAR)) |-> $past(ram_re))
    else $error("header written without a preceding read");

endmodule
